// ===== src/rau_pkg.sv =====
// Shared types, widths and helpers for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH + 1;
    localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH + 1;
    localparam int DEN_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        op_t                               opcode;
        logic signed [OPERAND_WIDTH-1:0]   a_num;
        logic signed [OPERAND_WIDTH-1:0]   a_den;
        logic signed [OPERAND_WIDTH-1:0]   b_num;
        logic signed [OPERAND_WIDTH-1:0]   b_den;
    } req_t;

    typedef struct packed {
        logic signed [NUM_WIDTH-1:0] res_num;
        logic signed [DEN_WIDTH-1:0] res_den;
        status_t                     status;
    } res_t;

    function automatic logic [OPERAND_WIDTH-1:0] mag_of(logic signed [OPERAND_WIDTH-1:0] x);
        logic [OPERAND_WIDTH-1:0] u;
        u = x;
        return x[OPERAND_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

// ===== src/rau_gcd.sv =====
// Binary gcd engine, one reduction step per cycle.
module rau_gcd (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rau_pkg::MAG_WIDTH-1:0]  a,
    input  logic [rau_pkg::MAG_WIDTH-1:0]  b,
    output logic                           done,
    output logic [rau_pkg::MAG_WIDTH-1:0]  g
);
    logic [rau_pkg::MAG_WIDTH-1:0] a_reg, a_next, b_reg, b_next;
    logic [rau_pkg::CNT_WIDTH-1:0] k_reg, k_next;
    logic                          run_reg, run_next;

    assign done = run_reg && (a_reg == '0 || b_reg == '0);
    assign g    = (a_reg | b_reg) << k_reg;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        k_next   = k_reg;
        run_next = run_reg;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
                a_next = a_reg >> 1;
            else if (!b_reg[0])
                b_next = b_reg >> 1;
            else if (a_reg >= b_reg)
                a_next = (a_reg - b_reg) >> 1;
            else
                b_next = (b_reg - a_reg) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end
endmodule

// ===== src/rau_div.sv =====
// Restoring divider: numerator and denominator divided by the gcd in lockstep.
module rau_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rau_pkg::MAG_WIDTH-1:0]  n,
    input  logic [rau_pkg::MAG_WIDTH-1:0]  d,
    input  logic [rau_pkg::MAG_WIDTH-1:0]  g,
    output logic                           done,
    output logic [rau_pkg::MAG_WIDTH-1:0]  qn,
    output logic [rau_pkg::MAG_WIDTH-1:0]  qd
);
    localparam int MW = rau_pkg::MAG_WIDTH;

    logic [MW-1:0]                 g_reg, qn_reg, qd_reg;
    logic [MW:0]                   rn_reg, rd_reg;
    logic [rau_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic                          done_reg;
    logic [MW:0]                   rn_sh, rd_sh, g_ext;

    assign g_ext = {1'b0, g_reg};
    assign rn_sh = {rn_reg[MW-1:0], qn_reg[MW-1]};
    assign rd_sh = {rd_reg[MW-1:0], qd_reg[MW-1]};
    assign done  = done_reg;
    assign qn    = qn_reg;
    assign qd    = qd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == rau_pkg::CNT_WIDTH'(1));
            if (start)
                cnt_reg <= rau_pkg::CNT_WIDTH'(MW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            g_reg  <= g;
            qn_reg <= n;
            qd_reg <= d;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (rn_sh >= g_ext)
            begin
                rn_reg <= rn_sh - g_ext;
                qn_reg <= {qn_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= rn_sh;
                qn_reg <= {qn_reg[MW-2:0], 1'b0};
            end
            if (rd_sh >= g_ext)
            begin
                rd_reg <= rd_sh - g_ext;
                qd_reg <= {qd_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= rd_sh;
                qd_reg <= {qd_reg[MW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier, result register.
//
// Command interface. A request is taken at a rising edge with start high and
// busy low; operands carries the opcode and both fractions. One result per
// request appears on result for exactly one cycle with done high.
// Timing: a request with a zero input denominator, or a divide by a zero
// fraction, reports its status the cycle after it is taken, busy stays low.
// Otherwise the single shared multiplier forms the three products in turn in
// S_MUL, S_ADD combines the cross terms, the binary gcd reduces in S_GCD,
// and the two divisions by the gcd run side by side in S_DIV; busy is high
// throughout and falls in the cycle done rises, so the next request may be
// taken then.
// Reset clears the sequencer and the strobe; no result is pending afterwards.
// The receiver cannot stall: a result must be taken in its strobe cycle.
module rational_arithmetic_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t operands,
    output logic          done,
    output rau_pkg::res_t result
);
    localparam int W  = rau_pkg::OPERAND_WIDTH;
    localparam int MW = rau_pkg::MAG_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_GCD  = 5'b01000,
        S_DIV  = 5'b10000
    } state_t;

    state_t          state_reg;
    logic [1:0]      cnt_reg;
    rau_pkg::req_t   req_reg;
    logic [2*W-1:0]  m1_reg, m2_reg, dm_reg;
    logic            m1neg_reg, m2neg_reg, dneg_reg, nneg_reg;
    logic [MW-1:0]   nm_reg;
    rau_pkg::res_t   res_reg;
    logic            done_reg;

    logic signed [W-1:0] mx, my;
    logic [2*W-1:0]      prod;
    logic                pneg;
    logic [MW-1:0]       nsum;
    logic                nsum_neg, m2neg_eff;
    logic                gcd_done, div_done;
    logic [MW-1:0]       g, qn, qd;
    logic                accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mx = req_reg.a_num;
                my = (req_reg.opcode == rau_pkg::OP_MUL) ? req_reg.b_num : req_reg.b_den;
            end
            2'd1:
            begin
                mx = req_reg.a_den;
                my = (req_reg.opcode == rau_pkg::OP_DIV) ? req_reg.b_num : req_reg.b_den;
            end
            default:
            begin
                mx = req_reg.a_den;
                my = req_reg.b_num;
            end
        endcase
        pneg = mx[W-1] ^ my[W-1];
        prod = (2*W)'(rau_pkg::mag_of(mx)) * (2*W)'(rau_pkg::mag_of(my));
    end

    // combine cross terms as sign and magnitude
    always_comb
    begin
        m2neg_eff = m2neg_reg ^ (req_reg.opcode == rau_pkg::OP_SUB);
        nsum      = MW'(m1_reg);
        nsum_neg  = m1neg_reg;
        if (req_reg.opcode == rau_pkg::OP_ADD || req_reg.opcode == rau_pkg::OP_SUB)
        begin
            if (m1neg_reg == m2neg_eff)
                nsum = MW'(m1_reg) + MW'(m2_reg);
            else if (m1_reg >= m2_reg)
                nsum = MW'(m1_reg - m2_reg);
            else
            begin
                nsum     = MW'(m2_reg - m1_reg);
                nsum_neg = m2neg_eff;
            end
        end
    end

    rau_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_ADD),
        .a     (nsum),
        .b     (MW'(dm_reg)),
        .done  (gcd_done),
        .g     (g)
    );

    rau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_GCD && gcd_done),
        .n     (nm_reg),
        .d     (MW'(dm_reg)),
        .g     (g),
        .done  (div_done),
        .qn    (qn),
        .qd    (qd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                        if (operands.a_den == '0 || operands.b_den == '0 ||
                            (operands.opcode == rau_pkg::OP_DIV && operands.b_num == '0))
                            done_reg <= 1'b1;
                        else
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd2)
                        state_reg <= S_ADD;
                end
                S_ADD:
                    state_reg <= S_GCD;
                S_GCD:
                    if (gcd_done)
                        state_reg <= S_DIV;
                S_DIV:
                    if (div_done)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg         <= operands;
            res_reg.res_num <= '0;
            res_reg.res_den <= '0;
            if (operands.a_den == '0 || operands.b_den == '0)
                res_reg.status <= rau_pkg::ST_ZERO_DEN;
            else if (operands.opcode == rau_pkg::OP_DIV && operands.b_num == '0)
                res_reg.status <= rau_pkg::ST_DIV_ZERO;
            else
                res_reg.status <= rau_pkg::ST_OK;
        end
        if (state_reg == S_MUL)
        begin
            case (cnt_reg)
                2'd0:
                begin
                    m1_reg    <= prod;
                    m1neg_reg <= pneg;
                end
                2'd1:
                begin
                    dm_reg   <= prod;
                    dneg_reg <= pneg;
                end
                default:
                begin
                    m2_reg    <= prod;
                    m2neg_reg <= pneg;
                end
            endcase
        end
        if (state_reg == S_ADD)
        begin
            nm_reg   <= nsum;
            nneg_reg <= nsum_neg;
        end
        if (state_reg == S_DIV && div_done)
        begin
            res_reg.res_num <= nneg_reg ? rau_pkg::NUM_WIDTH'(~qn + 1'b1)
                                        : rau_pkg::NUM_WIDTH'(qn);
            res_reg.res_den <= dneg_reg ? rau_pkg::DEN_WIDTH'(~qd + 1'b1)
                                        : rau_pkg::DEN_WIDTH'(qd);
        end
    end
endmodule

// ===== src/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input rau_pkg::res_t result
);
    // a taken request either keeps the unit busy or reports at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("request taken but neither busy nor done");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start && !busy))
        else $error("result with no request behind it");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != rau_pkg::ST_OK |->
            result.res_num == '0 && result.res_den == '0)
        else $error("error result carries nonzero fields");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == rau_pkg::ST_OK |-> result.res_den != '0)
        else $error("good result with zero denominator");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== test/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: random and corner requests.
module rational_arithmetic_unit_tb;

    localparam int MAX_CYCLES = 1000000;
    localparam int OW         = rau_pkg::OPERAND_WIDTH;
    localparam int NW         = rau_pkg::NUM_WIDTH;
    localparam int DW         = rau_pkg::DEN_WIDTH;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic           done;
    rau_pkg::req_t  operands;
    rau_pkg::res_t  result;

    rau_pkg::req_t  pending_reqs[$];
    rau_pkg::res_t  expected_fracs[$];
    int    gap_left;
    int    n_errors;
    int    cycle_count;
    bit    stim_done;

    rational_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operands(operands), .done(done), .result(result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // exact fraction arithmetic in 64 bits, then reduced; each part keeps its sign
    function automatic rau_pkg::res_t reduce_fraction(rau_pkg::req_t r);
        rau_pkg::res_t o;
        longint an, ad, bn, bd, n, d;
        longint unsigned nm, dm, g;
        an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
        o = '0;
        o.status = rau_pkg::ST_OK;
        if (ad == 0 || bd == 0)
        begin
            o.status = rau_pkg::ST_ZERO_DEN;
            return o;
        end
        if (r.opcode == rau_pkg::OP_DIV && bn == 0)
        begin
            o.status = rau_pkg::ST_DIV_ZERO;
            return o;
        end
        case (r.opcode)
            rau_pkg::OP_ADD:
            begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            rau_pkg::OP_SUB:
            begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            rau_pkg::OP_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            default:
            begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd64(nm, dm);
        if (g != 0)
        begin
            nm = nm / g;
            dm = dm / g;
        end
        o.res_num = NW'((n < 0) ? -nm : nm);
        o.res_den = DW'((d < 0) ? -dm : dm);
        return o;
    endfunction

    function automatic logic [OW-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return OW'($urandom_range(0, 16) - 8);   // small values hit reductions often
            default: return OW'($urandom);
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 150);
        return $urandom_range(1, 4);
    endfunction

    task automatic queue_req(rau_pkg::op_t op, int an, int ad, int bn, int bd);
        rau_pkg::req_t r;
        r.opcode = op;
        r.a_num = OW'(an); r.a_den = OW'(ad); r.b_num = OW'(bn); r.b_den = OW'(bd);
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        rau_pkg::req_t r;
        rst_n = 1'b0;
        stim_done = 1'b0;
        for (int o = 0; o < 4; o++)
        begin
            queue_req(rau_pkg::op_t'(o), 1, 2, 1, 3);
            queue_req(rau_pkg::op_t'(o), -32768, -32768, -32768, -32768);
            queue_req(rau_pkg::op_t'(o), 32767, -32768, -32768, 32767);
            queue_req(rau_pkg::op_t'(o), 0, -5, 0, 7);
        end
        queue_req(rau_pkg::OP_ADD, 3, 0, 1, 1);
        queue_req(rau_pkg::OP_MUL, 3, 4, 1, 0);
        queue_req(rau_pkg::OP_DIV, 3, 4, 0, 5);
        queue_req(rau_pkg::OP_DIV, 0, 0, 0, 0);
        queue_req(rau_pkg::OP_SUB, 5, 6, 5, 6);
        queue_req(rau_pkg::OP_DIV, 0, -3, 4, 7);
        queue_req(rau_pkg::OP_MUL, 0, -3, 4, -7);
        for (int i = 0; i < 1550; i++)
        begin
            r.opcode = rau_pkg::op_t'($urandom_range(0, 3));
            r.a_num = rand_operand();
            r.a_den = rand_operand();
            r.b_num = rand_operand();
            r.b_den = rand_operand();
            pending_reqs.push_back(r);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_fracs.size() == 0);
        repeat (200) @(posedge clk);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            operands <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_fracs.push_back(reduce_fraction(operands));
                void'(pending_reqs.pop_front());
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    start    <= 1'b1;
                    operands <= pending_reqs[0];
                    if (start && !busy)
                        gap_left <= rand_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rau_pkg::res_t e;
        if (rst_n && done)
        begin
            if (expected_fracs.size() == 0)
            begin
                $error("unexpected result num=%0d den=%0d", result.res_num, result.res_den);
                n_errors++;
            end
            else
            begin
                e = expected_fracs.pop_front();
                if (result.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, result.status);
                    n_errors++;
                end
                if (result.res_num !== e.res_num)
                begin
                    $error("res_num expected %0d actual %0d", e.res_num, result.res_num);
                    n_errors++;
                end
                if (result.res_den !== e.res_den)
                begin
                    $error("res_den expected %0d actual %0d", e.res_den, result.res_den);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        n_errors = 0;
        cycle_count = 0;
        while (!stim_done && cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (stim_done && n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== rational_arithmetic_unit.f =====
src/rau_pkg.sv
src/rau_gcd.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
test/rational_arithmetic_unit_tb.sv
